/* hw/rtl/puc_pkg.sv */
// Shared types and constants of the pixel replication upscaler.
package puc_pkg;

  // Default sizing of the line store and of the scale range
  localparam int unsigned MAX_WIDTH   = 2048;
  localparam int unsigned MAX_SCALE   = 128;

  // Entries of the queue between classifier and output side
  localparam int unsigned QUEUE_DEPTH = 4;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // Request kinds
  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE    = 2'd0,
    REG_IN_WIDTH = 2'd1
  } reg_idx_e;

  // One output run as it travels from classifier to output
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] repeat_count;
    logic       row_end;
    logic [1:0] pad_bytes;
    logic       refused;
  } run_t;

endpackage

/* hw/rtl/puc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module puc_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/puc_front.sv */
// Front end: config registers, request classification, row state and line store.
module puc_front #(
  parameter int unsigned MaxWidth = puc_pkg::MAX_WIDTH,
  parameter int unsigned MaxScale = puc_pkg::MAX_SCALE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [puc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [puc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           q_stall_i,
  input  logic                           cmd_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  output logic                           push_o,
  output puc_pkg::run_t                  run_o
);

  localparam int unsigned AddrW    = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned ScaleCap = (MaxScale < 255) ? MaxScale : 255;
  localparam int unsigned WidthCap = (MaxWidth < 4095) ? MaxWidth : 4095;
  localparam int unsigned RpW      = (ScaleCap > 1) ? $clog2(ScaleCap) : 1;
  localparam int unsigned CmpW     = (AddrW + 1 > 12) ? AddrW + 1 : 12;

  // Configuration registers
  logic [7:0]  scale_q;
  logic [11:0] in_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= 8'd1;
      in_width_q <= 12'd1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == puc_pkg::REG_SCALE) begin
        scale_q <= cfg_data_i[7:0];
      end else if (cfg_idx_i == puc_pkg::REG_IN_WIDTH) begin
        in_width_q <= cfg_data_i;
      end
    end
  end

  // Clamp the registers into their usable ranges
  logic [7:0]  eff_scale;
  logic [11:0] eff_width;

  always_comb begin
    if (scale_q == 8'd0) begin
      eff_scale = 8'd1;
    end else if (scale_q > 8'(ScaleCap)) begin
      eff_scale = 8'(ScaleCap);
    end else begin
      eff_scale = scale_q;
    end
    if (in_width_q == 12'd0) begin
      eff_width = 12'd1;
    end else if (in_width_q > 12'(WidthCap)) begin
      eff_width = 12'(WidthCap);
    end else begin
      eff_width = in_width_q;
    end
  end

  // Row state
  logic [AddrW-1:0] col_q, col_d;
  logic [RpW-1:0]   rp_q, rp_d;

  logic       accept;
  logic       is_pixel;
  logic       pending;
  logic       last;
  logic [1:0] pad;
  logic [3:0] pad_prod;
  logic       do_write;
  logic       do_replay;
  logic       do_refuse;

  assign accept    = in_valid_i && !q_stall_i;
  assign is_pixel  = (cmd_i == puc_pkg::CMD_PIXEL);
  assign pending   = (rp_q != '0);
  assign last      = (CmpW'(col_q) + CmpW'(1)) >= CmpW'(eff_width);
  assign pad_prod  = {2'b00, eff_width[1:0]} * {2'b00, eff_scale[1:0]};
  assign pad       = pad_prod[1:0];
  assign do_write  = accept && is_pixel && !pending;
  assign do_replay = accept && !is_pixel && pending;
  assign do_refuse = accept && is_pixel && pending;

  // Advance column and pending rows on every pixel write and every replay run
  always_comb begin
    col_d = col_q;
    rp_d  = rp_q;
    if (do_write || do_replay) begin
      if (last) begin
        col_d = '0;
        rp_d  = do_write ? RpW'(eff_scale - 8'd1) : rp_q - 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      rp_q  <= '0;
    end else begin
      col_q <= col_d;
      rp_q  <= rp_d;
    end
  end

  // Line store: write pixels, read for replay rows
  logic [23:0] rdata;

  puc_ram #(
    .Width (24),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (col_q),
    .wdata_i ({red_i, green_i, blue_i}),
    .re_i    (do_replay),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // Stage register that waits for the line store read
  logic          s1_valid_q;
  logic          s1_replay_q;
  puc_pkg::run_t s1_run_q;
  puc_pkg::run_t s1_run_d;

  always_comb begin
    s1_run_d = '0;
    if (do_refuse) begin
      s1_run_d.refused = 1'b1;
    end else begin
      s1_run_d.red          = red_i;
      s1_run_d.green        = green_i;
      s1_run_d.blue         = blue_i;
      s1_run_d.repeat_count = eff_scale;
      s1_run_d.row_end      = last;
      s1_run_d.pad_bytes    = last ? pad : 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_replay_q <= 1'b0;
    end else begin
      s1_valid_q  <= do_write || do_replay || do_refuse;
      s1_replay_q <= do_replay;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_run_q <= s1_run_d;
  end

  // Take the pixel from the line store for replay runs
  always_comb begin
    run_o = s1_run_q;
    if (s1_replay_q) begin
      run_o.red   = rdata[23:16];
      run_o.green = rdata[15:8];
      run_o.blue  = rdata[7:0];
    end
  end

  assign push_o = s1_valid_q;

  // A replay run is only issued while rows were pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_replay |=> s1_valid_q && s1_replay_q && ($past(rp_q) != '0))
    else $error("replay run issued with no pending rows");

  // Pending rows never exceed the scale cap minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= RpW'(ScaleCap - 1))
    else $error("pending row count out of range");

endmodule

/* hw/rtl/puc_queue.sv */
// Back end: run queue that decouples the classifier from the output handshake.
module puc_queue #(
  parameter int unsigned Depth = puc_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  puc_pkg::run_t run_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output puc_pkg::run_t run_o,
  output logic          stall_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1) + 1;

  puc_pkg::run_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign run_o       = mem_q[rd_ptr_q];

  // Hold off new requests when the run in flight could not find a slot
  assign stall_o = (count_q + CntW'(push_i)) >= CntW'(Depth);

  // Store pushed runs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= run_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop);
    end
  end

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q < CntW'(Depth)))
    else $error("run pushed into full queue");

  // Occupancy tracks pushes and pops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + CntW'($past(push_i)) - CntW'($past(pop)))
    else $error("queue occupancy mismatch");

endmodule

/* hw/rtl/pixel_replication_upscaler.sv */
// Top level of the pixel replication upscaler.
// Takes one request per cycle: a pixel (cmd 0) is stored in the line buffer and answered by
// one run repeating it scale times; after the last pixel of a row, scale-1 replay rows are
// pending and each drain request (cmd 1) returns one buffered run in column order, while a
// pixel that arrives meanwhile is answered with a refused run. A drain with nothing pending
// gives no run. A run reaches the output through the stage that waits for the registered
// line buffer read, then the output queue. The sustained rate is one request per cycle; the
// input stalls only when the four-entry output queue fills because the output side stalls.
// The line buffer has no clearing pass: every entry is written before it is replayed. Write
// scale and in_width only while the block is idle.
module pixel_replication_upscaler #(
  parameter int unsigned MaxWidth = puc_pkg::MAX_WIDTH,
  parameter int unsigned MaxScale = puc_pkg::MAX_SCALE
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [puc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [puc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_red_o,
  output logic [7:0]                     out_green_o,
  output logic [7:0]                     out_blue_o,
  output logic [7:0]                     repeat_count_o,
  output logic                           row_end_o,
  output logic [1:0]                     pad_bytes_o,
  output logic                           refused_o
);

  logic          push;
  logic          q_stall;
  puc_pkg::run_t push_run;
  puc_pkg::run_t head_run;

  // Classify requests and keep row state
  puc_front #(
    .MaxWidth (MaxWidth),
    .MaxScale (MaxScale)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .q_stall_i  (q_stall),
    .cmd_i      (cmd_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .push_o     (push),
    .run_o      (push_run)
  );

  // Queue runs toward the output
  puc_queue #(
    .Depth (puc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .run_i       (push_run),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .run_o       (head_run),
    .stall_o     (q_stall)
  );

  assign in_stall_o     = q_stall;
  assign out_red_o      = head_run.red;
  assign out_green_o    = head_run.green;
  assign out_blue_o     = head_run.blue;
  assign repeat_count_o = head_run.repeat_count;
  assign row_end_o      = head_run.row_end;
  assign pad_bytes_o    = head_run.pad_bytes;
  assign refused_o      = head_run.refused;

endmodule
